// File: src/led_text_scroll_motion_macros.svh
// Assertion macros used by the scroll motion divider.
`ifndef LED_TEXT_SCROLL_MOTION_MACROS_SVH
`define LED_TEXT_SCROLL_MOTION_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LTSM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ltsm: same-cycle check failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LTSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ltsm: next-cycle check failed");
`else
`define LTSM_ASSERT_IMP(lbl, ante, cons)
`define LTSM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/ltsm_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package ltsm_pkg;

    // Fixed-point and field widths
    localparam int FRAC_BITS  = 8;
    localparam int TIME_W     = 40;
    localparam int POS_W      = 24;
    localparam int CYC_W      = 16;
    localparam int REP_W      = 8;
    localparam int CTL_W      = 4;
    localparam int SPD_W      = 10;
    localparam int HOLD_W     = 16;
    localparam int PER_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((TIME_W + REP_W + 7) / 8) * 8;
    localparam int OUT_FLD_W  = POS_W + 3 + CYC_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // Step per tick: (speed * 2^FRAC_BITS + 100) / 200 by reciprocal multiply
    localparam int NUM_W  = SPD_W + FRAC_BITS + 1;
    localparam int DLT_W  = FRAC_BITS + 3;
    localparam int DLT_SH = FRAC_BITS + 19;
    localparam longint unsigned DLT_MUL = ((64'd1 << DLT_SH) + 64'd199) / 64'd200;
    localparam int MUL_W  = $clog2(DLT_MUL + 1);
    localparam int PROD_W = NUM_W + MUL_W;

    // Loop wrap arithmetic
    localparam int PQ_W  = PER_W + FRAC_BITS;
    localparam int WR_W  = (POS_W + 2 > PQ_W + 1) ? POS_W + 2 : PQ_W + 1;
    localparam int DVD_W = POS_W - FRAC_BITS;
    localparam int DVS_W = PER_W;
    localparam int CSUM_W = ((DVD_W > CYC_W) ? DVD_W : CYC_W) + 1;

    // Register reset values
    localparam logic [SPD_W-1:0] SPEED_RESET = SPD_W'(100);
    localparam logic [REP_W-1:0] REP_NONE    = '0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd7;

    // Control register fields
    localparam logic [1:0] MODE_STATIC = 2'd0;
    localparam logic [1:0] MODE_ONCE   = 2'd1;
    localparam logic [1:0] MODE_LOOP   = 2'd2;
    localparam logic [1:0] MODE_BOUNCE = 2'd3;
    localparam int CTL_LEFT = 2;
    localparam int CTL_OFFS = 3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic apply;
        logic div_start;
        logic wrap;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_div;
        logic div_busy;
    } t_sts;

endpackage

// File: src/ltsm_div.sv
// Serial restoring divider for the loop wrap count, one quotient bit per cycle.
`include "led_text_scroll_motion_macros.svh"

module ltsm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ltsm_pkg::DVD_W-1:0]   i_dividend,
    input  logic [ltsm_pkg::DVS_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic [ltsm_pkg::DVD_W-1:0]   o_quot,
    output logic [ltsm_pkg::DVS_W-1:0]   o_rem
);

    localparam int CNT_W = $clog2(ltsm_pkg::DVD_W + 1);

    logic [CNT_W-1:0]              r_cnt;
    logic [ltsm_pkg::DVD_W-1:0]    r_q;
    logic [ltsm_pkg::DVS_W-1:0]    r_r;
    logic [ltsm_pkg::DVS_W-1:0]    r_dvs;
    logic [ltsm_pkg::DVS_W:0]      w_shift;
    logic [ltsm_pkg::DVS_W:0]      w_sub;
    logic                          w_ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_shift = {r_r, r_q[ltsm_pkg::DVD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_sub   = w_shift - {1'b0, r_dvs};

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(ltsm_pkg::DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_r   <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_r <= w_ge ? w_sub[ltsm_pkg::DVS_W-1:0] : w_shift[ltsm_pkg::DVS_W-1:0];
            r_q <= {r_q[ltsm_pkg::DVD_W-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_q;
    assign o_rem  = r_r;

    `LTSM_ASSERT_NEXT(a_div_start_busy, i_start, o_busy)
    `LTSM_ASSERT_IMP(a_div_rem_range, $fell(o_busy) && (r_dvs != '0), o_rem < r_dvs)
    `LTSM_ASSERT_NEXT(a_div_dvs_hold, o_busy && !i_start, $stable(r_dvs))

endmodule

// File: src/ltsm_datapath.sv
// Datapath: registers, step arithmetic, mode update and result register.
module ltsm_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ltsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ltsm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_action,
    input  logic [ltsm_pkg::TIME_W-1:0]       i_in_now,
    input  logic [ltsm_pkg::REP_W-1:0]        i_in_repeat,
    input  ltsm_pkg::t_cmd                    i_cmd,
    output ltsm_pkg::t_sts                    o_sts,
    output logic signed [ltsm_pkg::POS_W-1:0] o_position,
    output logic                              o_is_moving,
    output logic                              o_is_returning,
    output logic [ltsm_pkg::CYC_W-1:0]        o_cycle_count,
    output logic                              o_is_finished
);

    localparam int POS_W  = ltsm_pkg::POS_W;
    localparam int TIME_W = ltsm_pkg::TIME_W;
    localparam int CYC_W  = ltsm_pkg::CYC_W;
    localparam int WR_W   = ltsm_pkg::WR_W;
    localparam int FB     = ltsm_pkg::FRAC_BITS;

    typedef enum logic [2:0] {
        P_RESTART = 3'd0,
        P_TOUCH   = 3'd1,
        P_FINI    = 3'd2,
        P_NONE    = 3'd3,
        P_HOLD    = 3'd4,
        P_EQ      = 3'd5,
        P_MOVE    = 3'd6
    } t_path;

    // Configuration registers
    logic [ltsm_pkg::CTL_W-1:0]   r_control;
    logic [ltsm_pkg::SPD_W-1:0]   r_speed;
    logic [ltsm_pkg::HOLD_W-1:0]  r_hold;
    logic signed [POS_W-1:0]      r_start;
    logic signed [POS_W-1:0]      r_near;
    logic signed [POS_W-1:0]      r_far;
    logic signed [POS_W-1:0]      r_end;
    logic [ltsm_pkg::PER_W-1:0]   r_period;

    // Motion state and its next values
    logic signed [POS_W-1:0]      r_pos,  n_pos;
    logic [TIME_W-1:0]            r_last, n_last;
    logic [TIME_W-1:0]            r_hdl,  n_hdl;
    logic                         r_mov,  n_mov;
    logic                         r_ret,  n_ret;
    logic [CYC_W-1:0]             r_cyc,  n_cyc;

    // Captured item and evaluation results
    logic                         r_act;
    logic [TIME_W-1:0]            r_now;
    logic [ltsm_pkg::REP_W-1:0]   r_rep;
    logic signed [POS_W-1:0]      r_p1;
    logic [TIME_W-1:0]            r_dl;
    t_path                        r_path;
    logic                         r_up;
    logic [ltsm_pkg::DLT_W-1:0]   r_delta;

    // Combinational terms
    logic [ltsm_pkg::NUM_W-1:0]   w_num;
    logic [ltsm_pkg::PROD_W-1:0]  w_prod;
    logic [1:0]                   w_mode;
    logic                         w_left;
    logic                         w_offs;
    logic signed [POS_W-1:0]      w_from;
    logic signed [POS_W-1:0]      w_to;
    logic signed [POS_W-1:0]      w_target;
    logic                         w_up;
    logic                         w_fwd;
    logic signed [POS_W:0]        w_pos_x;
    logic signed [POS_W:0]        w_dlt_x;
    logic signed [POS_W:0]        w_sum;
    logic signed [POS_W-1:0]      w_sat;
    logic [TIME_W:0]              w_dl_sum;
    logic [TIME_W-1:0]            w_dl;
    logic                         w_fin;
    t_path                        w_path;
    logic [ltsm_pkg::PQ_W-1:0]    w_perq;
    logic signed [WR_W-1:0]       w_perq_x;
    logic signed [WR_W-1:0]       w_ref_x;
    logic signed [WR_W-1:0]       w_p1_x;
    logic signed [WR_W-1:0]       w_diff;
    logic                         w_need_div;
    logic [ltsm_pkg::DVD_W-1:0]   w_quot;
    logic [ltsm_pkg::DVS_W-1:0]   w_rem;
    logic                         w_div_busy;
    logic [ltsm_pkg::PQ_W-1:0]    w_rem_full;
    logic signed [WR_W-1:0]       w_rem_x;
    logic signed [WR_W-1:0]       w_wrap;
    logic [ltsm_pkg::CSUM_W-1:0]  w_cyc_k;
    logic [CYC_W-1:0]             w_cyc_ksat;
    logic [CYC_W-1:0]             w_cyc_inc;
    logic                         w_fin_inc;
    logic                         w_end_hit;
    logic                         w_reach;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_speed   <= ltsm_pkg::SPEED_RESET;
            r_hold    <= '0;
            r_start   <= '0;
            r_near    <= '0;
            r_far     <= '0;
            r_end     <= '0;
            r_period  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ltsm_pkg::CFG_CONTROL: r_control <= i_cfg_data[ltsm_pkg::CTL_W-1:0];
                ltsm_pkg::CFG_SPEED:   r_speed   <= i_cfg_data[ltsm_pkg::SPD_W-1:0];
                ltsm_pkg::CFG_HOLD:    r_hold    <= i_cfg_data[ltsm_pkg::HOLD_W-1:0];
                ltsm_pkg::CFG_START:   r_start   <= i_cfg_data[POS_W-1:0];
                ltsm_pkg::CFG_NEAR:    r_near    <= i_cfg_data[POS_W-1:0];
                ltsm_pkg::CFG_FAR:     r_far     <= i_cfg_data[POS_W-1:0];
                ltsm_pkg::CFG_END:     r_end     <= i_cfg_data[POS_W-1:0];
                ltsm_pkg::CFG_PERIOD:  r_period  <= i_cfg_data[ltsm_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    // Step size: reciprocal multiply by 1/200, exact over the speed range
    assign w_num  = ltsm_pkg::NUM_W'({r_speed, {FB{1'b0}}}) + ltsm_pkg::NUM_W'(100);
    assign w_prod = ltsm_pkg::PROD_W'(w_num) * ltsm_pkg::PROD_W'(ltsm_pkg::DLT_MUL);

    always_ff @(posedge i_clk) begin
        r_delta <= w_prod[ltsm_pkg::DLT_SH +: ltsm_pkg::DLT_W];
    end

    // Control decode and bounce target
    assign w_mode   = r_control[1:0];
    assign w_left   = r_control[ltsm_pkg::CTL_LEFT];
    assign w_offs   = r_control[ltsm_pkg::CTL_OFFS];
    assign w_from   = w_left ? r_near : r_far;
    assign w_to     = w_left ? r_far : r_near;
    assign w_target = r_ret ? w_from : w_to;
    assign w_up     = w_target > r_pos;
    assign w_fwd    = (w_mode == ltsm_pkg::MODE_BOUNCE) ? w_up : !w_left;

    // Saturating step
    assign w_pos_x = (POS_W + 1)'(r_pos);
    assign w_dlt_x = signed'((POS_W + 1)'(r_delta));
    assign w_sum   = w_fwd ? (w_pos_x + w_dlt_x) : (w_pos_x - w_dlt_x);

    always_comb begin
        if (w_sum[POS_W] != w_sum[POS_W-1]) begin
            w_sat = w_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[POS_W-1:0];
        end
    end

    // Saturating hold deadline
    assign w_dl_sum = {1'b0, r_now} + (TIME_W + 1)'(r_hold);
    assign w_dl     = w_dl_sum[TIME_W] ? {TIME_W{1'b1}} : w_dl_sum[TIME_W-1:0];

    assign w_fin = (r_rep != ltsm_pkg::REP_NONE) && (r_cyc >= CYC_W'(r_rep));

    // Classify the item; order decides
    always_comb begin
        priority if (r_act) begin
            w_path = P_RESTART;
        end else if (w_mode == ltsm_pkg::MODE_STATIC) begin
            w_path = P_TOUCH;
        end else if (w_fin) begin
            w_path = P_FINI;
        end else if (r_now <= r_last) begin
            w_path = P_NONE;
        end else if (r_now <= r_hdl) begin
            w_path = P_HOLD;
        end else if ((w_mode == ltsm_pkg::MODE_BOUNCE) && (w_from == w_to)) begin
            w_path = P_EQ;
        end else begin
            w_path = P_MOVE;
        end
    end

    // Capture the item and the evaluation stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= i_in_action;
            r_now <= i_in_now;
            r_rep <= i_in_repeat;
        end
        if (i_cmd.eval) begin
            r_p1   <= w_sat;
            r_dl   <= w_dl;
            r_path <= w_path;
            r_up   <= w_up;
        end
    end

    // Loop wrap test: distance past the start by at least one period
    assign w_perq   = {r_period, {FB{1'b0}}};
    assign w_perq_x = signed'(WR_W'(w_perq));
    assign w_ref_x  = WR_W'(r_start);
    assign w_p1_x   = WR_W'(r_p1);
    assign w_diff   = w_left ? (w_ref_x - w_p1_x) : (w_p1_x - w_ref_x);
    assign w_need_div = (r_path == P_MOVE) && (w_mode == ltsm_pkg::MODE_LOOP) &&
                        (r_period != '0) && (w_diff >= w_perq_x);

    // Whole periods in the pixel part of the distance
    ltsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_diff[POS_W-1:FB]),
        .i_divisor  (r_period),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign o_sts.need_div = w_need_div;
    assign o_sts.div_busy = w_div_busy;

    assign w_rem_full = {w_rem, w_diff[FB-1:0]};
    assign w_rem_x    = signed'(WR_W'(w_rem_full));
    assign w_wrap     = w_left ? (w_ref_x - w_rem_x) : (w_ref_x + w_rem_x);
    assign w_cyc_k    = ltsm_pkg::CSUM_W'(r_cyc) + ltsm_pkg::CSUM_W'(w_quot);
    assign w_cyc_ksat = (w_cyc_k > ltsm_pkg::CSUM_W'({CYC_W{1'b1}})) ? {CYC_W{1'b1}} :
                        w_cyc_k[CYC_W-1:0];

    // Once and bounce end tests
    assign w_cyc_inc = (r_cyc == {CYC_W{1'b1}}) ? r_cyc : r_cyc + CYC_W'(1);
    assign w_fin_inc = (r_rep != ltsm_pkg::REP_NONE) && (w_cyc_inc >= CYC_W'(r_rep));
    assign w_end_hit = w_left ? (r_p1 <= r_end) : (r_p1 >= r_end);
    assign w_reach   = r_up ? (r_p1 >= w_target) : (r_p1 <= w_target);

    // Next motion state
    always_comb begin
        n_pos  = r_pos;
        n_last = r_last;
        n_hdl  = r_hdl;
        n_mov  = r_mov;
        n_ret  = r_ret;
        n_cyc  = r_cyc;
        if (i_cmd.wrap) begin
            n_pos  = w_wrap[POS_W-1:0];
            n_last = r_now;
            n_mov  = 1'b1;
            n_cyc  = w_cyc_ksat;
        end else if (i_cmd.apply) begin
            unique case (r_path)
                P_RESTART: begin
                    n_cyc  = '0;
                    n_pos  = r_start;
                    n_last = r_now;
                    n_hdl  = w_offs ? r_now : r_dl;
                    n_mov  = 1'b0;
                    n_ret  = 1'b0;
                end
                P_TOUCH, P_HOLD: begin
                    n_last = r_now;
                end
                P_FINI: begin
                    n_last = r_now;
                    n_mov  = 1'b0;
                end
                P_NONE: ;
                P_EQ: begin
                    n_last = r_now;
                    n_mov  = 1'b1;
                end
                P_MOVE: begin
                    n_last = r_now;
                    n_mov  = 1'b1;
                    unique case (w_mode)
                        ltsm_pkg::MODE_BOUNCE: begin
                            if (!w_reach) begin
                                n_pos = r_p1;
                            end else begin
                                n_pos = w_target;
                                n_ret = !r_ret;
                                n_hdl = r_dl;
                                n_mov = 1'b0;
                                if (r_ret) begin
                                    n_cyc = w_cyc_inc;
                                end
                            end
                        end
                        ltsm_pkg::MODE_LOOP: begin
                            n_pos = r_p1;
                        end
                        ltsm_pkg::MODE_ONCE: begin
                            n_pos = r_p1;
                            if (w_end_hit) begin
                                n_cyc = w_cyc_inc;
                                n_mov = 1'b0;
                                if (!w_fin_inc) begin
                                    // Start the next pass
                                    n_pos = r_start;
                                    n_hdl = w_offs ? r_now : r_dl;
                                    n_ret = 1'b0;
                                end
                            end
                        end
                        ltsm_pkg::MODE_STATIC: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_last <= '0;
            r_hdl  <= '0;
            r_mov  <= 1'b0;
            r_ret  <= 1'b0;
            r_cyc  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_last <= n_last;
            r_hdl  <= n_hdl;
            r_mov  <= n_mov;
            r_ret  <= n_ret;
            r_cyc  <= n_cyc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_position     <= r_pos;
            o_is_moving    <= r_mov;
            o_is_returning <= r_ret;
            o_cycle_count  <= r_cyc;
            o_is_finished  <= w_fin;
        end
    end

endmodule

// File: src/ltsm_ctrl.sv
// Controller: sequences capture, evaluation, wrap division and result hand-off.
module ltsm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ltsm_pkg::t_sts  i_sts,
    output ltsm_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_APPLY = 6'b000100,
        S_DIV   = 6'b001000,
        S_WRAP  = 6'b010000,
        S_PUSH  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_APPLY;
            end
            S_APPLY: begin
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_PUSH;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                // Hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result beat valid: set on load, drop when taken
    assign n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: src/led_text_scroll_motion.sv
// Top level of the scrolling text motion block: stream ports and packing.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata now_ms, repeat_limit; tuser action
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata position, flags, cycle_count
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
//  An item is captured, evaluated and applied, then loaded into the output register; the
//  next item is taken only once that result is loaded. When a loop wrap is due, the serial
//  divider runs between the apply and wrap steps before the result is loaded.
//  Reset is synchronous and clears the motion state; registers take their reset values.
//  A result waits in the output register while the next item is taken; with that
//  register still full, the controller holds the following result back.
module led_text_scroll_motion (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: now_ms, repeat_limit
    input  logic [ltsm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser bit 0: action
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: position, is_moving, is_returning, cycle_count, is_finished, zero pad
    output logic [ltsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ltsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ltsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int TIME_W = ltsm_pkg::TIME_W;
    localparam int REP_W  = ltsm_pkg::REP_W;

    ltsm_pkg::t_cmd                    w_cmd;
    ltsm_pkg::t_sts                    w_sts;
    logic signed [ltsm_pkg::POS_W-1:0] w_position;
    logic                              w_is_moving;
    logic                              w_is_returning;
    logic [ltsm_pkg::CYC_W-1:0]        w_cycle_count;
    logic                              w_is_finished;

    // Registers accept a write beat every cycle
    assign o_cfg_ready = 1'b1;

    ltsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ltsm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_action    (s_axis_tuser[0]),
        .i_in_now       (s_axis_tdata[TIME_W-1:0]),
        .i_in_repeat    (s_axis_tdata[TIME_W +: REP_W]),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_position     (w_position),
        .o_is_moving    (w_is_moving),
        .o_is_returning (w_is_returning),
        .o_cycle_count  (w_cycle_count),
        .o_is_finished  (w_is_finished)
    );

    // Pack the result beat
    assign m_axis_tdata = ltsm_pkg::OUT_DATA_W'({w_is_finished, w_cycle_count,
                                                 w_is_returning, w_is_moving,
                                                 w_position});

endmodule

// File: tb/led_text_scroll_motion_test.sv
// Self-checking stream testbench for the scrolling text motion block.
`timescale 1ns / 100ps

module led_text_scroll_motion_test;
    import ltsm_pkg::*;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;
    localparam logic [POS_W-1:0] POS_TOP = 24'h7F_FFFF;
    localparam logic [POS_W-1:0] POS_BOT = 24'h80_0000;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;
    localparam int PHASES           = 16;
    localparam int PHASE_ITEMS      = 68;
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 40;
    localparam int RUN_LIMIT        = 500000;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             moving;
        logic             returning;
        logic [CYC_W-1:0] cycles;
        logic             finished;
    } t_motion_report;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic                  act;
        logic [TIME_W-1:0]     now;
        logic [REP_W-1:0]      rep;
        bit                    rest;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    led_text_scroll_motion uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Mirror of the block's registers and motion state
    logic [CTL_W-1:0]        cfg_ctl = '0;
    logic [SPD_W-1:0]        cfg_speed = SPEED_RESET;
    logic [HOLD_W-1:0]       cfg_hold = '0;
    logic signed [POS_W-1:0] cfg_start = '0;
    logic signed [POS_W-1:0] cfg_near = '0;
    logic signed [POS_W-1:0] cfg_far = '0;
    logic signed [POS_W-1:0] cfg_end = '0;
    logic [PER_W-1:0]        cfg_period = '0;
    logic signed [POS_W-1:0] st_pos = '0;
    logic [TIME_W-1:0]       st_last = '0;
    logic [TIME_W-1:0]       st_deadline = '0;
    logic                    st_moving = 1'b0;
    logic                    st_returning = 1'b0;
    logic [CYC_W-1:0]        st_cycles = '0;

    t_motion_report motion_reports_due[$];
    bit             rest_state_q[$];
    t_script_row    script[$];

    int items_sent = 0;
    int restarts_sent = 0;
    int reports_seen = 0;
    int cfg_writes = 0;
    int fault_count = 0;
    int run_cycles = 0;
    int tx_idle_pct = 29;
    int rx_idle_pct = 71;
    int rx_hold_left = 0;
    bit long_hold_done = 1'b0;

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_pos(input longint v);
        if (v > longint'($signed(POS_TOP))) return longint'($signed(POS_TOP));
        if (v < longint'($signed(POS_BOT))) return longint'($signed(POS_BOT));
        return v;
    endfunction

    function automatic logic [TIME_W-1:0] hold_until(input logic [TIME_W-1:0] now);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + cfg_hold;
        return sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
    endfunction

    function automatic void count_cycles(input longint k);
        longint total;
        total = longint'(st_cycles) + k;
        st_cycles = (total > 65535) ? '1 : CYC_W'(total);
    endfunction

    function automatic bit reached(input logic [REP_W-1:0] rep);
        return rep != 0 && st_cycles >= rep;
    endfunction

    function automatic void restart_from(input logic [TIME_W-1:0] now);
        st_pos = cfg_start;
        st_last = now;
        st_deadline = cfg_ctl[CTL_OFFS] ? now : hold_until(now);
        st_moving = 1'b0;
        st_returning = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_CONTROL: cfg_ctl = val[CTL_W-1:0];
            CFG_SPEED:   cfg_speed = val[SPD_W-1:0];
            CFG_HOLD:    cfg_hold = val[HOLD_W-1:0];
            CFG_START:   cfg_start = val[POS_W-1:0];
            CFG_NEAR:    cfg_near = val[POS_W-1:0];
            CFG_FAR:     cfg_far = val[POS_W-1:0];
            CFG_END:     cfg_end = val[POS_W-1:0];
            CFG_PERIOD:  cfg_period = val[PER_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the motion state by one beat and return the report it produces
    function automatic t_motion_report advance_motion(input logic act,
                                                      input logic [TIME_W-1:0] now,
                                                      input logic [REP_W-1:0] rep);
        t_motion_report rpt;
        longint step, p, per_q, base, k, leg_from, leg_to, target;
        logic left, up;
        left = cfg_ctl[CTL_LEFT];
        step = ((longint'(cfg_speed) << FRAC_BITS) + 100) / 200;
        if (act == ACT_RESTART) begin
            st_cycles = '0;
            restart_from(now);
        end else if (cfg_ctl[1:0] == MODE_STATIC) begin
            st_last = now;
        end else if (reached(rep)) begin
            st_last = now;
            st_moving = 1'b0;
        end else if (now > st_last) begin
            st_last = now;
            if (now > st_deadline) begin
                st_moving = 1'b1;
                if (cfg_ctl[1:0] == MODE_BOUNCE) begin
                    leg_from = left ? longint'(cfg_near) : longint'(cfg_far);
                    leg_to = left ? longint'(cfg_far) : longint'(cfg_near);
                    // equal anchors: flag motion but hold the position
                    if (leg_from != leg_to) begin
                        target = st_returning ? leg_from : leg_to;
                        up = target > longint'(st_pos);
                        p = clamp_pos(up ? longint'(st_pos) + step : longint'(st_pos) - step);
                        if (up ? p < target : p > target) begin
                            st_pos = POS_W'(p);
                        end else begin
                            st_pos = POS_W'(target);
                            st_returning = !st_returning;
                            st_deadline = hold_until(now);
                            st_moving = 1'b0;
                            if (!st_returning) count_cycles(1);
                        end
                    end
                end else begin
                    p = clamp_pos(left ? longint'(st_pos) - step : longint'(st_pos) + step);
                    if (cfg_ctl[1:0] == MODE_LOOP) begin
                        // remove every whole period that is due in one go
                        per_q = longint'(cfg_period) << FRAC_BITS;
                        base = longint'(cfg_start);
                        if (per_q > 0) begin
                            if (left && p <= base - per_q) begin
                                k = (base - p) / per_q;
                                p = p + k * per_q;
                                count_cycles(k);
                            end else if (!left && p >= base + per_q) begin
                                k = (p - base) / per_q;
                                p = p - k * per_q;
                                count_cycles(k);
                            end
                        end
                        st_pos = POS_W'(p);
                    end else begin
                        st_pos = POS_W'(p);
                        if (left ? p <= longint'(cfg_end) : p >= longint'(cfg_end)) begin
                            count_cycles(1);
                            if (reached(rep)) st_moving = 1'b0;
                            else restart_from(now);
                        end
                    end
                end
            end
        end
        rpt.position = st_pos;
        rpt.moving = st_moving;
        rpt.returning = st_returning;
        rpt.cycles = st_cycles;
        rpt.finished = reached(rep);
        return rpt;
    endfunction

    // ---------------------------------------------------------------- scoreboard

    always @(posedge i_clk) begin : scoreboard
        t_motion_report want, got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            // predict every accepted input beat
            if (s_axis_tvalid && s_axis_tready) begin
                want = advance_motion(s_axis_tuser[0], s_axis_tdata[TIME_W-1:0],
                                      s_axis_tdata[TIME_W +: REP_W]);
                if (rest_state_q.size() != 0 && rest_state_q.pop_front()) want = '0;
                motion_reports_due.push_back(want);
            end
            // check every accepted output beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                reports_seen++;
                got.position = m_axis_tdata[POS_W-1:0];
                got.moving = m_axis_tdata[POS_W];
                got.returning = m_axis_tdata[POS_W+1];
                got.cycles = m_axis_tdata[POS_W+2 +: CYC_W];
                got.finished = m_axis_tdata[POS_W+2+CYC_W];
                if (motion_reports_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: report with none pending: pos %0d cyc %0d", $time,
                                 $signed(got.position), got.cycles);
                end else begin
                    want = motion_reports_due.pop_front();
                    if (got !== want) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display({"%0t: mismatch exp pos %0d mov %0b ret %0b cyc %0d ",
                                      "fin %0b, got pos %0d mov %0b ret %0b cyc %0d fin %0b"},
                                     $time, $signed(want.position), want.moving,
                                     want.returning, want.cycles, want.finished,
                                     $signed(got.position), got.moving, got.returning,
                                     got.cycles, got.finished);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Random back-pressure, plus one long hold-off once the run is well under way
    always @(posedge i_clk) begin
        if (!long_hold_done && items_sent >= LONG_HOLD_AT) begin
            long_hold_done <= 1'b1;
            rx_hold_left <= LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        run_cycles++;
        if (run_cycles == RUN_LIMIT) begin
            $display("Timed out after %0d cycles", run_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sender

    task automatic offer_item(input logic act, input logic [TIME_W-1:0] now,
                              input logic [REP_W-1:0] rep, input bit rest);
        rest_state_q.push_back(rest);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rep, now};
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (act == ACT_RESTART) restarts_sent++;
    endtask

    // Stop offering and wait until every report is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (reports_seen != items_sent) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
    endtask

    function automatic void item_row(input logic act, input logic [TIME_W-1:0] now,
                                     input logic [REP_W-1:0] rep, input bit rest);
        t_script_row row;
        row = '{ROW_ITEM, '0, '0, act, now, rep, rest};
        script.push_back(row);
    endfunction

    function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        t_script_row row;
        row = '{ROW_REG, idx, val, ACT_TICK, '0, '0, 1'b0};
        script.push_back(row);
    endfunction

    // Random fixed-point x within +/- span pixels
    function automatic logic [POS_W-1:0] near_px(input int span);
        int px;
        px = int'($urandom_range(2 * span)) - span;
        return POS_W'(px * 256 + int'($urandom_range(255)));
    endfunction

    initial begin : stimulus
        bit in_cfg;
        int ph, n, r, gap;
        logic [CTL_W-1:0]  ctl;
        logic [SPD_W-1:0]  spd;
        logic [HOLD_W-1:0] hold;
        logic [PER_W-1:0]  per;
        logic [POS_W-1:0]  st, en, nr, fr;
        logic [TIME_W-1:0] clock_ms, now;
        logic [TIME_W:0]   tsum;
        logic [REP_W-1:0]  phase_rep, rep;

        // Directed rows; rest = the report must be the all-zero rest state
        item_row(ACT_TICK, '0, '0, 1'b1);                 // static after reset
        item_row(ACT_TICK, TIME_TOP, '1, 1'b1);           // time and repeat at their top
        item_row(ACT_RESTART, '0, '0, 1'b1);
        reg_row(CFG_CONTROL, CFG_DATA_W'({1'b0, 1'b0, MODE_ONCE}));
        reg_row(CFG_SPEED, 24'd1000);
        reg_row(CFG_HOLD, 24'd5);
        reg_row(CFG_END, 24'd768);
        item_row(ACT_RESTART, 40'd100, 8'd1, 1'b1);
        item_row(ACT_TICK, 40'd100, 8'd1, 1'b1);          // time not advancing
        item_row(ACT_TICK, 40'd105, 8'd1, 1'b1);          // still in the hold
        item_row(ACT_TICK, 40'd106, 8'd1, 1'b0);          // overshoot, finishes
        item_row(ACT_TICK, 40'd107, 8'd1, 1'b0);          // finished stays put
        item_row(ACT_TICK, 40'd108, 8'd0, 1'b0);          // endless, restarts
        reg_row(CFG_HOLD, 24'hFFFF);
        item_row(ACT_RESTART, TIME_TOP - 40'd15, 8'd0, 1'b0);   // deadline saturates
        item_row(ACT_TICK, TIME_TOP, 8'd0, 1'b0);
        reg_row(CFG_CONTROL, CFG_DATA_W'({1'b0, 1'b0, MODE_LOOP}));
        reg_row(CFG_SPEED, 24'd1023);
        reg_row(CFG_HOLD, 24'd0);
        reg_row(CFG_START, POS_TOP);
        item_row(ACT_RESTART, 40'd1000, 8'd0, 1'b0);
        // far-off reference: many periods due at once, cycle count saturates
        reg_row(CFG_START, POS_BOT);
        reg_row(CFG_PERIOD, 24'd1);
        item_row(ACT_TICK, 40'd1001, 8'd0, 1'b0);
        item_row(ACT_TICK, 40'd1002, 8'd0, 1'b0);
        // no wrap period: runs into the bottom of the range
        reg_row(CFG_CONTROL, CFG_DATA_W'({1'b0, 1'b1, MODE_LOOP}));
        reg_row(CFG_PERIOD, 24'd0);
        item_row(ACT_RESTART, 40'd2000, 8'd0, 1'b0);
        item_row(ACT_TICK, 40'd2001, 8'd0, 1'b0);
        reg_row(CFG_CONTROL, CFG_DATA_W'({1'b0, 1'b0, MODE_BOUNCE}));
        reg_row(CFG_NEAR, 24'd256);
        reg_row(CFG_FAR, 24'd256);
        item_row(ACT_TICK, 40'd2002, 8'd0, 1'b0);         // equal anchors
        reg_row(CFG_CONTROL, CFG_DATA_W'({1'b1, 1'b0, MODE_BOUNCE}));
        reg_row(CFG_SPEED, 24'd1000);
        reg_row(CFG_HOLD, 24'd3);
        reg_row(CFG_START, 24'hFF_FE00);
        reg_row(CFG_NEAR, 24'd0);
        reg_row(CFG_FAR, 24'd1024);
        item_row(ACT_RESTART, 40'd3000, 8'd0, 1'b0);
        item_row(ACT_TICK, 40'd3001, 8'd0, 1'b0);         // reach near end
        item_row(ACT_TICK, 40'd3002, 8'd0, 1'b0);         // end hold
        item_row(ACT_TICK, 40'd3005, 8'd0, 1'b0);         // back at far end
        item_row(ACT_TICK, 40'd3009, 8'd1, 1'b0);         // limit reached

        // Hold reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed rows; register writes wait for an idle block
        in_cfg = 1'b0;
        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                if (!in_cfg) settle();
                in_cfg = 1'b1;
                write_reg(script[i].index, script[i].value);
            end else begin
                if (in_cfg) i_cfg_valid <= 1'b0;
                in_cfg = 1'b0;
                offer_item(script[i].act, script[i].now, script[i].rep, script[i].rest);
            end
        end

        // Random phases, one control value each
        clock_ms = '0;
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 6) begin
                tx_idle_pct = 71;
                rx_idle_pct = 29;
            end
            if (ph == 12) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            settle();

            ctl = CTL_W'(ph);
            r = $urandom_range(9);
            spd = (r == 0) ? SPD_W'(0) : (r == 1) ? SPD_W'(1023) : (r == 2) ? SPD_W'(1000) :
                  SPD_W'($urandom_range(150, 1023));
            r = $urandom_range(19);
            hold = (r == 0) ? HOLD_W'(16'hFFFF) : (r < 7) ? HOLD_W'(0) :
                   HOLD_W'($urandom_range(60));
            st = near_px(64);
            gap = int'($urandom_range(4, 60)) * 256 + int'($urandom_range(255));
            en = (cfg_ctl[CTL_LEFT] ^ ($urandom_range(6) == 0) ^ ctl[CTL_LEFT] ^ cfg_ctl[CTL_LEFT])
                 ? st - POS_W'(gap) : st + POS_W'(gap);
            nr = near_px(64);
            gap = int'($urandom_range(2, 40)) * 256 + int'($urandom_range(255));
            r = $urandom_range(9);
            fr = (r == 0) ? nr : (r < 5) ? nr + POS_W'(gap) : nr - POS_W'(gap);
            r = $urandom_range(19);
            per = (r < 2) ? PER_W'(0) : (r == 2) ? PER_W'(16'hFFFF) :
                  PER_W'($urandom_range(1, 40));
            if ($urandom_range(9) == 0) st = POS_W'($urandom);
            // one phase at the range limits, one with everything random
            if (ph == 3) begin
                spd = SPD_W'(1023);
                hold = '1;
                st = POS_BOT;
                en = POS_TOP;
                nr = POS_BOT;
                fr = POS_TOP;
                per = '1;
            end else if (ph == 10) begin
                spd = SPD_W'($urandom);
                hold = HOLD_W'($urandom);
                st = POS_W'($urandom);
                en = POS_W'($urandom);
                nr = POS_W'($urandom);
                fr = POS_W'($urandom);
                per = PER_W'($urandom);
            end
            write_reg(CFG_CONTROL, CFG_DATA_W'(ctl));
            write_reg(CFG_SPEED, CFG_DATA_W'(spd));
            write_reg(CFG_HOLD, CFG_DATA_W'(hold));
            write_reg(CFG_START, st);
            write_reg(CFG_NEAR, nr);
            write_reg(CFG_FAR, fr);
            write_reg(CFG_END, en);
            write_reg(CFG_PERIOD, CFG_DATA_W'(per));
            i_cfg_valid <= 1'b0;

            r = $urandom_range(9);
            phase_rep = (r < 4) ? REP_W'(0) : (r < 9) ? REP_W'($urandom_range(1, 4)) :
                        REP_W'($urandom);

            // Each phase opens with a restart, then mostly advancing ticks
            offer_item(ACT_RESTART, clock_ms, phase_rep, 1'b0);
            for (n = 1; n < PHASE_ITEMS; n++) begin
                rep = ($urandom_range(3) == 0) ? REP_W'($urandom) : phase_rep;
                r = $urandom_range(99);
                if (r < 4) begin
                    if ($urandom_range(9) < 3) begin
                        clock_ms = {8'($urandom), 32'($urandom)};
                    end else begin
                        tsum = {1'b0, clock_ms} + $urandom_range(20);
                        clock_ms = tsum[TIME_W] ? TIME_TOP : tsum[TIME_W-1:0];
                    end
                    offer_item(ACT_RESTART, clock_ms, rep, 1'b0);
                end else if (r < 9) begin
                    // stale or repeated time stamp
                    now = (clock_ms > 50) ? clock_ms - $urandom_range(50) : clock_ms;
                    offer_item(ACT_TICK, now, rep, 1'b0);
                end else begin
                    tsum = {1'b0, clock_ms} +
                           (($urandom_range(99) < 3) ? $urandom_range(70000) :
                                                       $urandom_range(1, 40));
                    clock_ms = tsum[TIME_W] ? TIME_TOP : tsum[TIME_W-1:0];
                    offer_item(ACT_TICK, clock_ms, rep, 1'b0);
                end
            end
        end

        // Drain, let the pipeline run dry, then judge
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (motion_reports_due.size() != 0) begin
            $display("%0d reports never arrived", motion_reports_due.size());
            fault_count += motion_reports_due.size();
        end
        $display("Run: %0d beats (%0d restarts), %0d register writes over %0d settings,",
                 items_sent, restarts_sent, cfg_writes, PHASES);
        $display("     all control values, wraps, bounce legs, holds and saturation cases.");
        if (fault_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/ltsm_pkg.sv
src/ltsm_div.sv
src/ltsm_datapath.sv
src/ltsm_ctrl.sv
src/led_text_scroll_motion.sv
tb/led_text_scroll_motion_test.sv
